// ===== hw/rtl/triangle_plane_equation_core_macros.svh =====
// Assertion macros for the triangle plane equation core.
// Used by the top level only; no other dependencies.
`ifndef TRIANGLE_PLANE_EQUATION_CORE_MACROS_SVH
`define TRIANGLE_PLANE_EQUATION_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define TPE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define TPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpe_pkg.sv =====
// Shared types and constants for the triangle plane equation core.
// No dependencies.
`timescale 1ns / 1ps

package tpe_pkg;

    localparam int NORM_BITS  = 32;
    localparam int Q30        = 30;
    localparam int MANT_BITS  = 31;   // scaled magnitude, max largest < 2^30
    localparam int SUM_BITS   = 62;   // sum of three squares of 30-bit values
    localparam int ROOT_BITS  = 31;
    localparam int QUO_BITS   = 31;   // quotient, at most 2^30
    localparam int DIVD_BITS  = 61;   // m << 30 plus rounding
    // vertex fraction bits; plane_d keeps the vertex format, so no stage depends on it
    localparam int FRAC_BITS  = 16;

    // Control word carried from cell to cell.
    typedef struct packed {
        logic valid;
        logic degen;
    } tpe_ctl_t;

endpackage

// ===== hw/rtl/tpe_sqrt_cell.sv =====
// One restoring square root step: produces one root bit a cycle.
// Depends on tpe_pkg.
`timescale 1ns / 1ps

module tpe_sqrt_cell
    import tpe_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic                  clk,
    input  logic [SUM_BITS-1:0]   rem_in,
    input  logic [ROOT_BITS-1:0]  root_in,
    output logic [SUM_BITS-1:0]   rem_out,
    output logic [ROOT_BITS-1:0]  root_out
);

    // Bit weight of this step: root bit (ROOT_BITS-1-STEP)
    localparam int RB = ROOT_BITS - 1 - STEP;

    logic [SUM_BITS+1:0] trial;
    logic [SUM_BITS+1:0] rem_w;

    always_comb
    begin
        // (root + 2^RB)^2 - root^2 = 2*root*2^RB + 2^(2RB)
        trial = ({{(SUM_BITS+2-ROOT_BITS){1'b0}}, root_in} << (RB + 1))
              + ({{(SUM_BITS+1){1'b0}}, 1'b1} << (2 * RB));
        rem_w = {2'b00, rem_in};
    end

    always_ff @(posedge clk)
    begin
        if (rem_w >= trial)
        begin
            rem_out  <= SUM_BITS'(rem_w - trial);
            root_out <= root_in | (ROOT_BITS'(1) << RB);
        end
        else
        begin
            rem_out  <= rem_in;
            root_out <= root_in;
        end
    end

endmodule

// ===== hw/rtl/tpe_div_cell.sv =====
// One restoring division step for three dividends sharing one divisor.
// Depends on tpe_pkg.
`timescale 1ns / 1ps

module tpe_div_cell
    import tpe_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic                  clk,
    input  logic [ROOT_BITS-1:0]  dvs,
    input  logic [DIVD_BITS-1:0]  rem_in  [3],
    input  logic [QUO_BITS-1:0]   quo_in  [3],
    output logic [DIVD_BITS-1:0]  rem_out [3],
    output logic [QUO_BITS-1:0]   quo_out [3]
);

    localparam int QB = QUO_BITS - 1 - STEP;

    logic [DIVD_BITS+QUO_BITS-1:0] shd;

    always_comb
    begin
        shd = {{QUO_BITS{1'b0}}, {(DIVD_BITS-ROOT_BITS){1'b0}}, dvs} << QB;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if ({{QUO_BITS{1'b0}}, rem_in[i]} >= shd)
            begin
                rem_out[i] <= DIVD_BITS'({{QUO_BITS{1'b0}}, rem_in[i]} - shd);
                quo_out[i] <= quo_in[i] | (QUO_BITS'(1) << QB);
            end
            else
            begin
                rem_out[i] <= rem_in[i];
                quo_out[i] <= quo_in[i];
            end
        end
    end

endmodule

// ===== hw/rtl/triangle_plane_equation_core.sv =====
// Top level of the triangle plane equation core: pipeline of cells.
// Depends on tpe_pkg, tpe_sqrt_cell, tpe_div_cell and the macros header.
//
//  channel | dir | tdata fields (low bit up)                 | tuser
//  s_axis  | in  | ax ay az bx by bz cx cy cz (COORD_BITS)     | -
//  m_axis  | out | nx ny nz (32 each) plane_d (COORD_BITS)     | degenerate
//
// One face a cycle; LAT = 71 register stages: edge, products, cross, magnitude, shift, squares,
// 31 square root cells, 31 divider cells, sign, dot products, sum and round.
// The pipeline advances as a whole whenever the output register is free or being
// read; a stall freezes every stage. Reset clears only the control bits.
`timescale 1ns / 1ps
`include "triangle_plane_equation_core_macros.svh"

module triangle_plane_equation_core
    import tpe_pkg::*;
#(
    parameter int COORD_BITS = 32,
    localparam int TD_IN     = ((9 * COORD_BITS + 7) / 8) * 8,
    localparam int TD_OUT    = ((3 * NORM_BITS + COORD_BITS + 7) / 8) * 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz
    input  logic [TD_IN-1:0]             s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // nx, ny, nz, plane_d, zero fill
    output logic [TD_OUT-1:0]            m_axis_tdata,
    // degenerate
    output logic                         m_axis_tuser
);

    localparam int EB     = COORD_BITS + 1;         // edge width
    localparam int PB     = 2 * EB;                 // product width
    localparam int XB     = PB + 1;                 // cross component width
    localparam int LB     = $clog2(XB + 1);         // bit-length width
    localparam int DB     = NORM_BITS + COORD_BITS + 3; // dot sum width
    localparam int NSQ    = ROOT_BITS;
    localparam int NDV    = QUO_BITS;
    // stages: 0 edge,1 prod,2 cross,3 mag+len,4 shift,5 square,
    // sqrt cells, div cells, sign, dot, sum/out
    localparam int LAT    = 6 + NSQ + NDV + 3;
    localparam int DV0    = 6 + NSQ;            // stage index of first divider cell
    localparam int SN     = DV0 + NDV - 1;      // stage of divider output

    // stall control: all stages move together
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    tpe_ctl_t ctl_reg [LAT];
    // first vertex delayed along the pipe
    logic signed [COORD_BITS-1:0] a_reg [SN+2][3];
    logic [2:0] sgn_reg [3:SN];

    // stage 0: edges
    logic signed [EB-1:0] e1_reg [3];
    logic signed [EB-1:0] e2_reg [3];
    // stage 1: products
    logic signed [PB-1:0] p_reg [6];
    // stage 2: cross
    logic signed [XB-1:0] x_reg [3];
    // stage 3: magnitudes and bit-length
    logic [XB-1:0] xm_reg [3];
    logic [LB-1:0] ml_reg;
    // stage 4 on: scaled magnitudes
    logic [MANT_BITS-1:0] m_reg [4:DV0-1][3];
    // stage 5: sum of squares
    logic [SUM_BITS-1:0] sq_reg;

    logic signed [COORD_BITS-1:0] a_in [3];
    logic signed [COORD_BITS-1:0] b_in [3];
    logic signed [COORD_BITS-1:0] c_in [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_in[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
            b_in[i] = s_axis_tdata[(3+i)*COORD_BITS +: COORD_BITS];
            c_in[i] = s_axis_tdata[(6+i)*COORD_BITS +: COORD_BITS];
        end
    end

    // valid chain; the zero-area flag joins at stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[0].valid <= s_axis_tvalid;
            ctl_reg[0].degen <= 1'b0;
            for (int s = 1; s < LAT; s++)
            begin
                if (s != 3)
                begin
                    ctl_reg[s] <= ctl_reg[s-1];
                end
            end
            ctl_reg[3].valid <= ctl_reg[2].valid;
            ctl_reg[3].degen <= ctl_reg[2].valid && (x_reg[0] == '0)
                              && (x_reg[1] == '0) && (x_reg[2] == '0);
        end
    end

    // bit length of the largest magnitude
    logic [XB-1:0] orm;
    logic [LB-1:0] blen;
    logic [XB-1:0] xm_w [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xm_w[i] = x_reg[i][XB-1] ? XB'(-x_reg[i]) : XB'(x_reg[i]);
        end
        orm  = xm_w[0] | xm_w[1] | xm_w[2];
        blen = '0;
        for (int k = 0; k < XB; k++)
        begin
            if (orm[k])
            begin
                blen = LB'(k + 1);
            end
        end
    end

    // payload stages up to the square root, and the vertex, sign and magnitude delay lines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg[0] <= a_in;
            for (int s = 1; s <= SN + 1; s++)
            begin
                a_reg[s] <= a_reg[s-1];
            end
            for (int s = 4; s <= SN; s++)
            begin
                sgn_reg[s] <= sgn_reg[s-1];
            end
            for (int s = 5; s < DV0; s++)
            begin
                m_reg[s] <= m_reg[s-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EB'(b_in[i]) - EB'(a_in[i]);
                e2_reg[i] <= EB'(c_in[i]) - EB'(a_in[i]);
            end
            p_reg[0] <= PB'(e1_reg[1]) * PB'(e2_reg[2]);
            p_reg[1] <= PB'(e2_reg[1]) * PB'(e1_reg[2]);
            p_reg[2] <= PB'(e1_reg[2]) * PB'(e2_reg[0]);
            p_reg[3] <= PB'(e2_reg[2]) * PB'(e1_reg[0]);
            p_reg[4] <= PB'(e1_reg[0]) * PB'(e2_reg[1]);
            p_reg[5] <= PB'(e2_reg[0]) * PB'(e1_reg[1]);
            for (int i = 0; i < 3; i++)
            begin
                x_reg[i] <= XB'(p_reg[2*i]) - XB'(p_reg[2*i+1]);
            end
            for (int i = 0; i < 3; i++)
            begin
                xm_reg[i]     <= xm_w[i];
                sgn_reg[3][i] <= x_reg[i][XB-1];
            end
            ml_reg <= blen;
            for (int i = 0; i < 3; i++)
            begin
                if (ml_reg > LB'(Q30))
                begin
                    m_reg[4][i] <= MANT_BITS'(xm_reg[i] >> (ml_reg - LB'(Q30)));
                end
                else
                begin
                    m_reg[4][i] <= MANT_BITS'(xm_reg[i] << (LB'(Q30) - ml_reg));
                end
            end
            sq_reg <= SUM_BITS'(m_reg[4][0] * m_reg[4][0])
                    + SUM_BITS'(m_reg[4][1] * m_reg[4][1])
                    + SUM_BITS'(m_reg[4][2] * m_reg[4][2]);
        end
    end

    // square root cell chain
    logic [SUM_BITS-1:0]  sr_rem  [NSQ+1];
    logic [ROOT_BITS-1:0] sr_root [NSQ+1];
    assign sr_rem[0]  = sq_reg;
    assign sr_root[0] = '0;

    for (genvar g = 0; g < NSQ; g++)
    begin : g_sqrt
        logic [SUM_BITS-1:0]  r_o;
        logic [ROOT_BITS-1:0] q_o;
        logic [SUM_BITS-1:0]  r_hold;
        logic [ROOT_BITS-1:0] q_hold;
        tpe_sqrt_cell #(.STEP(g)) u_cell
        (
            .clk      (clk),
            .rem_in   (adv ? sr_rem[g] : r_hold),
            .root_in  (adv ? sr_root[g] : q_hold),
            .rem_out  (r_o),
            .root_out (q_o)
        );
        // hold path: keep the previous inputs while stalled
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_hold <= sr_rem[g];
                q_hold <= sr_root[g];
            end
        end
        assign sr_rem[g+1]  = r_o;
        assign sr_root[g+1] = q_o;
    end

    // divider cell chain: dividends m<<30 + L/2
    logic [DIVD_BITS-1:0] dv_rem [NDV+1][3];
    logic [QUO_BITS-1:0]  dv_quo [NDV+1][3];
    logic [ROOT_BITS-1:0] dv_dvs [NDV+1];

    assign dv_dvs[0] = sr_root[NSQ];
    for (genvar i = 0; i < 3; i++)
    begin : g_dividend
        assign dv_rem[0][i] = (DIVD_BITS'(m_reg[DV0-1][i]) << Q30)
                            + DIVD_BITS'(sr_root[NSQ] >> 1);
        assign dv_quo[0][i] = '0;
    end

    for (genvar g = 0; g < NDV; g++)
    begin : g_div
        logic [DIVD_BITS-1:0] r_hold [3];
        logic [QUO_BITS-1:0]  q_hold [3];
        logic [ROOT_BITS-1:0] d_hold;
        logic [DIVD_BITS-1:0] r_sel  [3];
        logic [QUO_BITS-1:0]  q_sel  [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_sel[i] = adv ? dv_rem[g][i] : r_hold[i];
                q_sel[i] = adv ? dv_quo[g][i] : q_hold[i];
            end
        end
        // the held divisor doubles as the divisor for the next cell
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_hold <= dv_rem[g];
                q_hold <= dv_quo[g];
                d_hold <= dv_dvs[g];
            end
        end
        assign dv_dvs[g+1] = d_hold;
        tpe_div_cell #(.STEP(g)) u_cell
        (
            .clk     (clk),
            .dvs     (adv ? dv_dvs[g] : d_hold),
            .rem_in  (r_sel),
            .quo_in  (q_sel),
            .rem_out (dv_rem[g+1]),
            .quo_out (dv_quo[g+1])
        );
    end

    // normal, dot product, rounding
    logic signed [NORM_BITS-1:0] n_w [3];
    logic signed [NORM_BITS-1:0] n_reg [3];
    logic signed [NORM_BITS-1:0] n2_reg [3];
    logic signed [NORM_BITS+COORD_BITS-1:0] dp_reg [3];
    logic signed [NORM_BITS-1:0] nq_reg [3];
    logic [COORD_BITS-1:0] d_out_reg;
    logic signed [DB-1:0] s_w;
    logic signed [DB-1:0] r_w;
    logic signed [DB-Q30-1:0] sh_w;
    localparam logic signed [DB-Q30-1:0] DMAX = (DB-Q30)'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [DB-Q30-1:0] DMIN = (DB-Q30)'(-(64'sd1 <<< (COORD_BITS-1)));
    logic [COORD_BITS-1:0] dsat;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_w[i] = sgn_reg[SN][i] ? -NORM_BITS'(dv_quo[NDV][i])
                                    :  NORM_BITS'(dv_quo[NDV][i]);
        end
        s_w  = DB'(dp_reg[0]) + DB'(dp_reg[1]) + DB'(dp_reg[2]);
        r_w  = -s_w + DB'(64'sd1 <<< (Q30 - 1));
        sh_w = r_w[DB-1:Q30];
        if (sh_w > DMAX)
        begin
            dsat = COORD_BITS'(DMAX);
        end
        else if (sh_w < DMIN)
        begin
            dsat = COORD_BITS'(DMIN);
        end
        else
        begin
            dsat = COORD_BITS'(sh_w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg <= n_w;
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i] <= (NORM_BITS+COORD_BITS)'(n_reg[i])
                           * (NORM_BITS+COORD_BITS)'(a_reg[SN+1][i]);
            end
            n2_reg    <= n_reg;
            nq_reg    <= n2_reg;
            d_out_reg <= dsat;
        end
    end

    assign m_axis_tvalid = ctl_reg[LAT-1].valid;
    assign m_axis_tuser  = ctl_reg[LAT-1].degen;
    assign m_axis_tdata  = ctl_reg[LAT-1].degen ? '0 :
        TD_OUT'({d_out_reg, nq_reg[2], nq_reg[1], nq_reg[0]});

    `TPE_ASSERT_IMPL(a_degen_valid, clk, rst_n, m_axis_tuser, m_axis_tvalid,
        "degenerate flag without a valid transfer")
    `TPE_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output moved while stalled")
    `TPE_ASSERT_IMPL(a_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready,
        "input blocked with empty output")

endmodule
